// File: sv/hcc_pkg.sv
package hcc_pkg;

  // Field widths of the stream payloads
  localparam int FREQ_W  = 16;
  localparam int COST_W  = 28;
  localparam int IN_DW   = 16;
  localparam int OUT_DW  = 32;

  // Saturation limit of the reported cost
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_CHK,
    S_PUSH_CMP,
    S_MERGE_CHK,
    S_POP_TOP,
    S_POP_TAIL,
    S_POP_SET,
    S_SD_CHK,
    S_SD_KID,
    S_SD_SIB,
    S_FINISH
  } hcc_state_t;

endpackage

// File: sv/hcc_ram.sv
module hcc_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/huffman_code_cost.sv
// Huffman weighted path length of a set of symbol frequencies.
// Input stream: in_tdata carries one symbol frequency per request, in_tlast
// marks the final symbol of a set. Each frequency is inserted into a binary
// min-heap held in a single RAM (one write and one read port, read data
// registered). After the last symbol the two smallest entries are removed
// and their sum pushed back until one entry is left; all sums add up to the
// cost. Output stream: one request per set, total_cost in out_tdata and the
// overflow flag in out_tuser. Symbols beyond MAX_SYMBOLS are dropped and
// raise the flag.
// Sequencing: an insert takes the request, then a parent fetch and a compare
// per parent compared, and a root write when the entry climbs there; the
// next request is taken only once the insert ends. A removal reads the root,
// then the tail, then sets up the sift; each child compared takes a left
// child fetch, a sibling fetch if there is one and a compare, and a write
// places the tail when it sinks to a leaf. The single RAM read port sets the pace.
// Reset (synchronous, active low) empties the heap, clears the flag and
// drops any pending result. No clearing pass is needed. If the receiver
// stalls, the result holds in the output register while the next set is
// already taken in; the following result then waits until it drains.
module huffman_code_cost
  import hcc_pkg::*;
#(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [15:0] frequency
  input  logic              in_tlast,   // last_symbol
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [27:0] total_cost, [31:28] zero
  output logic              out_tuser   // [0] overflow
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int ENT_W = FREQ_W + $clog2(MAX_SYMBOLS);

  hcc_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  kid_r, kid_nxt;
  logic [ENT_W-1:0]  val_r, val_nxt;
  logic [ENT_W-1:0]  top_r, top_nxt;
  logic [ENT_W-1:0]  tail_r, tail_nxt;
  logic [ENT_W-1:0]  first_r, first_nxt;
  logic [ENT_W-1:0]  kval_r, kval_nxt;
  logic [COST_W-1:0] total_r, total_nxt;
  logic              ovf_r, ovf_nxt;
  logic              last_r, last_nxt;
  logic              second_r, second_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [COST_W-1:0] out_cost_r, out_cost_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              ram_we;
  logic [CNT_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [CNT_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  logic [CNT_W:0]    kid2;
  logic              kid_fits;
  logic              do_cmp;
  logic [ENT_W-1:0]  child_val;
  logic [CNT_W-1:0]  child_idx;
  logic              pop_end;
  logic              push_end;
  logic [ENT_W-1:0]  pair_sum;
  logic [COST_W:0]   cost_sum;

  hcc_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_SYMBOLS + 1)
  ) u_heap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign kid2      = {pos_r, 1'b0};
  assign kid_fits  = kid2 <= {1'b0, count_r};
  assign pair_sum  = first_r + top_r;
  assign cost_sum  = {1'b0, total_r} + (COST_W + 1)'(pair_sum);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_cost_r);
  assign out_tuser  = out_ovf_r;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      second_r    <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      second_r    <= second_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    kid_r      <= kid_nxt;
    val_r      <= val_nxt;
    top_r      <= top_nxt;
    tail_r     <= tail_nxt;
    first_r    <= first_nxt;
    kval_r     <= kval_nxt;
    out_cost_r <= out_cost_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Sequence heap inserts, removals and merges
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    kid_nxt       = kid_r;
    val_nxt       = val_r;
    top_nxt       = top_r;
    tail_nxt      = tail_r;
    first_nxt     = first_r;
    kval_nxt      = kval_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r;
    out_cost_nxt  = out_cost_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = val_r;
    ram_raddr     = '0;
    do_cmp        = 1'b0;
    child_val     = ram_rdata;
    child_idx     = kid_r;
    pop_end       = 1'b0;
    push_end      = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          last_nxt = in_tlast;
          if (count_r == CNT_W'(MAX_SYMBOLS)) begin
            ovf_nxt   = 1'b1;
            state_nxt = in_tlast ? S_MERGE_CHK : S_IDLE;
          end else begin
            val_nxt   = ENT_W'(in_tdata);
            count_nxt = count_r + 1'b1;
            pos_nxt   = count_r + 1'b1;
            state_nxt = S_PUSH_CHK;
          end
        end
      end

      // Sift up: fetch parent or place at root
      S_PUSH_CHK: begin
        if (pos_r > CNT_W'(1)) begin
          ram_raddr = pos_r >> 1;
          state_nxt = S_PUSH_CMP;
        end else begin
          ram_we   = 1'b1;
          push_end = 1'b1;
        end
      end

      S_PUSH_CMP: begin
        ram_we = 1'b1;
        if (val_r < ram_rdata) begin
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r >> 1;
          state_nxt = S_PUSH_CHK;
        end else begin
          push_end = 1'b1;
        end
      end

      S_MERGE_CHK: begin
        second_nxt = 1'b0;
        state_nxt  = (count_r > CNT_W'(1)) ? S_POP_TOP : S_FINISH;
      end

      // Removal: read root, then tail
      S_POP_TOP: begin
        ram_raddr = CNT_W'(1);
        state_nxt = S_POP_TAIL;
      end

      S_POP_TAIL: begin
        top_nxt   = ram_rdata;
        ram_raddr = count_r;
        state_nxt = S_POP_SET;
      end

      S_POP_SET: begin
        tail_nxt  = ram_rdata;
        count_nxt = count_r - 1'b1;
        pos_nxt   = CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          pop_end = 1'b1;
        end else begin
          state_nxt = S_SD_CHK;
        end
      end

      // Sift down: fetch left child or place tail
      S_SD_CHK: begin
        if (kid_fits) begin
          ram_raddr = kid2[CNT_W-1:0];
          kid_nxt   = kid2[CNT_W-1:0];
          state_nxt = S_SD_KID;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = tail_r;
          pop_end   = 1'b1;
        end
      end

      S_SD_KID: begin
        if (kid_r < count_r) begin
          kval_nxt  = ram_rdata;
          ram_raddr = kid_r + 1'b1;
          state_nxt = S_SD_SIB;
        end else begin
          do_cmp = 1'b1;
        end
      end

      S_SD_SIB: begin
        do_cmp = 1'b1;
        if (ram_rdata < kval_r) begin
          child_idx = kid_r + 1'b1;
        end else begin
          child_val = kval_r;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_cost_nxt  = total_r;
          out_ovf_nxt   = ovf_r;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          total_nxt     = '0;
          last_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Move smaller child up or settle the tail
    if (do_cmp) begin
      ram_we = 1'b1;
      if (tail_r <= child_val) begin
        ram_wdata = tail_r;
        pop_end   = 1'b1;
      end else begin
        ram_wdata = child_val;
        pos_nxt   = child_idx;
        state_nxt = S_SD_CHK;
      end
    end

    // Pair up removals and push back their sum
    if (pop_end) begin
      if (!second_r) begin
        first_nxt  = top_nxt;
        second_nxt = 1'b1;
        state_nxt  = S_POP_TOP;
      end else begin
        second_nxt = 1'b0;
        val_nxt    = pair_sum;
        total_nxt  = (cost_sum > (COST_W + 1)'(COST_MAX)) ? COST_MAX
                                                          : cost_sum[COST_W-1:0];
        pos_nxt    = count_nxt + 1'b1;
        count_nxt  = count_nxt + 1'b1;
        state_nxt  = S_PUSH_CHK;
      end
    end

    if (push_end) begin
      state_nxt = last_r ? S_MERGE_CHK : S_IDLE;
    end
  end

endmodule

// File: sv/hcc_checker.sv
module hcc_checker
  import hcc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tuser
);

  // No result survives reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A result never appears right after a symbol request
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result raised right after an input request");

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind huffman_code_cost hcc_checker u_hcc_checker (.*);
